### hdl/lrsc_pkg.sv
// Shared types and constants for the log record stream checker.
package lrsc_pkg;
    localparam logic [31:0] MAX_RECORD_BYTES = 32'd33554432;
    localparam logic [31:0] MAGIC_WORD       = 32'h35564B41;
    localparam logic [15:0] FORMAT_VERSION   = 16'h0001;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_POLY         = 32'h82F63B78;
    localparam logic [31:0] ENTRY_HDR_BYTES  = 32'd43;
    localparam logic [31:0] MIN_ENTRY_BYTES  = 32'd47;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_VERDICT = 2'd2,
        KIND_STREAM  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_BAD   = 3'd1,
        ST_SIZE_BAD  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_HDR   = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_FILE  = 2'd0,
        PH_ENTRY = 2'd1,
        PH_HALT  = 2'd2
    } phase_t;

    // classified result item carried from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [63:0] sequence_res;
        logic [63:0] source_node;
        logic [63:0] time_stamp;
        logic [7:0]  entry_flags;
        logic [15:0] key_length;
        logic [31:0] value_length;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction
endpackage

### hdl/lrsc_parser.sv
// Front part: parses bytes, tracks CRC and fields, produces result items.
module lrsc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_stream,
    output logic                 res_valid,
    output lrsc_pkg::result_t    res_data,
    input  logic                 res_ready
);
    lrsc_pkg::phase_t phase_reg, phase_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] cap_reg, cap_next;
    logic        mis_reg, mis_next;
    logic [63:0] seq_reg, seq_next, node_reg, node_next, time_reg, time_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] klen_reg, klen_next;
    logic [31:0] vlen_reg, vlen_next;
    logic [31:0] pay_off;
    logic [32:0] expect_len;
    logic [31:0] crc_upd, len_new;
    logic        fire;
    logic        res_hit;

    assign in_ready = res_ready;
    assign fire     = in_valid && in_ready;
    assign res_valid = res_hit && in_valid;
    assign pay_off  = off_reg - lrsc_pkg::ENTRY_HDR_BYTES;
    assign crc_upd  = lrsc_pkg::crc_byte(crc_reg, data_byte);
    assign len_new  = {data_byte, len_reg[31:8]};
    assign expect_len = 33'd47 + {17'd0, klen_reg} + {1'b0, vlen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lrsc_pkg::PH_FILE;
            off_reg   <= '0;
            len_reg   <= '0;
            crc_reg   <= lrsc_pkg::CRC_INIT;
            cap_reg   <= '0;
            mis_reg   <= 1'b0;
            seq_reg   <= '0;
            node_reg  <= '0;
            time_reg  <= '0;
            flags_reg <= '0;
            klen_reg  <= '0;
            vlen_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            cap_reg   <= cap_next;
            mis_reg   <= mis_next;
            seq_reg   <= seq_next;
            node_reg  <= node_next;
            time_reg  <= time_next;
            flags_reg <= flags_next;
            klen_reg  <= klen_next;
            vlen_reg  <= vlen_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        cap_next   = cap_reg;
        mis_next   = mis_reg;
        seq_next   = seq_reg;
        node_next  = node_reg;
        time_next  = time_reg;
        flags_next = flags_reg;
        klen_next  = klen_reg;
        vlen_next  = vlen_reg;
        res_hit    = 1'b0;
        res_data   = '0;
        case (phase_reg)
            lrsc_pkg::PH_FILE: begin
                if (end_of_stream) begin
                    phase_next      = lrsc_pkg::PH_HALT;
                    res_hit         = 1'b1;
                    res_data.kind   = lrsc_pkg::KIND_STREAM;
                    res_data.status = lrsc_pkg::ST_TRUNCATED;
                end else begin
                    if (off_reg < 32'd4) begin
                        if (data_byte != lrsc_pkg::MAGIC_WORD[8*off_reg[1:0] +: 8])
                            mis_next = 1'b1;
                    end else if (off_reg < 32'd6) begin
                        if (data_byte != lrsc_pkg::FORMAT_VERSION[8*off_reg[0] +: 8])
                            mis_next = 1'b1;
                    end
                    if (off_reg >= 32'd24 && off_reg < 32'd28) begin
                        cap_next = {data_byte, cap_reg[31:8]};
                        crc_next = lrsc_pkg::crc_byte(crc_reg, 8'd0);
                    end else begin
                        crc_next = crc_upd;
                    end
                    if (off_reg < 32'd31) begin
                        off_next = off_reg + 32'd1;
                    end else if (mis_next || ((crc_next ^ lrsc_pkg::CRC_INIT) != cap_next)) begin
                        phase_next      = lrsc_pkg::PH_HALT;
                        res_hit         = 1'b1;
                        res_data.kind   = lrsc_pkg::KIND_STREAM;
                        res_data.status = lrsc_pkg::ST_BAD_HDR;
                    end else begin
                        phase_next = lrsc_pkg::PH_ENTRY;
                        off_next   = '0;
                        crc_next   = lrsc_pkg::CRC_INIT;
                        cap_next   = '0;
                    end
                end
            end
            lrsc_pkg::PH_ENTRY: begin
                if (end_of_stream) begin
                    phase_next      = lrsc_pkg::PH_HALT;
                    res_hit         = 1'b1;
                    res_data.kind   = lrsc_pkg::KIND_STREAM;
                    res_data.status = (off_reg == '0) ? lrsc_pkg::ST_OK
                                                      : lrsc_pkg::ST_TRUNCATED;
                end else if (off_reg < 32'd4) begin
                    len_next = len_new;
                    crc_next = crc_upd;
                    off_next = off_reg + 32'd1;
                    if (off_reg == 32'd3 && (len_new < lrsc_pkg::MIN_ENTRY_BYTES ||
                                             len_new > lrsc_pkg::MAX_RECORD_BYTES)) begin
                        phase_next      = lrsc_pkg::PH_HALT;
                        res_hit         = 1'b1;
                        res_data.kind   = lrsc_pkg::KIND_STREAM;
                        res_data.status = lrsc_pkg::ST_BAD_LEN;
                    end
                end else if (off_reg < len_reg - 32'd4) begin
                    crc_next = crc_upd;
                    off_next = off_reg + 32'd1;
                    if (off_reg < 32'd12)      seq_next  = {data_byte, seq_reg[63:8]};
                    else if (off_reg < 32'd20) node_next = {data_byte, node_reg[63:8]};
                    else if (off_reg < 32'd28) time_next = {data_byte, time_reg[63:8]};
                    else if (off_reg == 32'd28) flags_next = data_byte;
                    else if (off_reg >= 32'd37 && off_reg < 32'd39)
                        klen_next = {data_byte, klen_reg[15:8]};
                    else if (off_reg >= 32'd39 && off_reg < 32'd43)
                        vlen_next = {data_byte, vlen_reg[31:8]};
                    if (off_reg >= lrsc_pkg::ENTRY_HDR_BYTES) begin
                        res_hit               = 1'b1;
                        res_data.kind         = (pay_off < {16'd0, klen_reg})
                                                ? lrsc_pkg::KIND_KEY : lrsc_pkg::KIND_VALUE;
                        res_data.payload_byte = data_byte;
                    end
                end else begin
                    cap_next = {data_byte, cap_reg[31:8]};
                    if (off_reg + 32'd1 < len_reg) begin
                        off_next = off_reg + 32'd1;
                    end else begin
                        res_hit               = 1'b1;
                        res_data.kind         = lrsc_pkg::KIND_VERDICT;
                        if ((crc_reg ^ lrsc_pkg::CRC_INIT) != cap_next)
                            res_data.status = lrsc_pkg::ST_CRC_BAD;
                        else if (expect_len != {1'b0, len_reg})
                            res_data.status = lrsc_pkg::ST_SIZE_BAD;
                        else
                            res_data.status = lrsc_pkg::ST_OK;
                        res_data.sequence_res = seq_reg;
                        res_data.source_node  = node_reg;
                        res_data.time_stamp   = time_reg;
                        res_data.entry_flags  = flags_reg;
                        res_data.key_length   = klen_reg;
                        res_data.value_length = vlen_reg;
                        off_next = '0;
                        crc_next = lrsc_pkg::CRC_INIT;
                    end
                end
            end
            default: begin
            end
        endcase
    end
endmodule

### hdl/lrsc_fifo.sv
// Back part: two-entry result queue driving the output beat.
module lrsc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  lrsc_pkg::result_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output lrsc_pkg::result_t rd_data
);
    lrsc_pkg::result_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (wr && !rd) cnt_next = cnt_reg + 2'd1;
        else if (rd && !wr) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

### hdl/log_record_stream_checker.sv
// Top level of the log record stream checker.
// Takes one file byte per beat on s_axis and accepts a beat every cycle
// while the two-entry result queue has room; each byte is parsed in the cycle
// it is accepted (byte-wide CRC32C update and field capture), so throughput is
// one byte per cycle; results come in the cycle after the beat at the earliest.
module log_record_stream_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte[7:0]
    input  logic          s_axis_tlast,   // end_of_stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // payload_byte[7:0], status[10:8], sequence_res[74:11], source_node[138:75],
    // time_stamp[202:139], entry_flags[210:203], key_length[226:211],
    // value_length[258:227], zero fill to 264
    output logic [263:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser    // kind
);
    lrsc_pkg::result_t res_data, out_data;
    logic res_valid, res_ready;

    lrsc_parser u_parser (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .end_of_stream(s_axis_tlast),
        .res_valid, .res_data, .res_ready
    );

    lrsc_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(res_valid), .wr_ready(res_ready), .wr_data(res_data),
        .rd_valid(m_axis_tvalid), .rd_ready(m_axis_tready), .rd_data(out_data)
    );

    assign m_axis_tuser = out_data.kind;
    assign m_axis_tdata = {5'd0, out_data.value_length, out_data.key_length,
                           out_data.entry_flags, out_data.time_stamp,
                           out_data.source_node, out_data.sequence_res,
                           out_data.status, out_data.payload_byte};
endmodule

### hdl/lrsc_checker.sv
// Port-level assertions for the log record stream checker, with bind.
module lrsc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [263:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[10:8] <= 3'd5)
        else $error("status out of range");
    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] == 1'b0 |-> m_axis_tdata[10:8] == 3'd0)
        else $error("payload beat carries a status");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");
endmodule

bind log_record_stream_checker lrsc_checker u_lrsc_checker (
    .aclk, .aresetn,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

### tb/sv/tb_top.sv
// Self-checking testbench for log_record_stream_checker: randomized file images.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TARGET_BYTES = 650;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [263:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    beat_t   file_beats[$];
    lrsc_pkg::result_t expected_results[$];
    int      byte_count = 0;
    int      errors = 0;
    int      cycles = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      send_burst = 1'b0;
    bit      recv_burst = 1'b0;

    // parser mirror
    lrsc_pkg::phase_t pr_phase = lrsc_pkg::PH_FILE;
    logic [31:0] pr_off = '0;
    logic [31:0] pr_len = '0;
    logic [31:0] pr_crc = lrsc_pkg::CRC_INIT;
    logic [31:0] pr_cap = '0;
    logic        pr_hdr_bad = 1'b0;
    logic [63:0] pr_seq = '0;
    logic [63:0] pr_node = '0;
    logic [63:0] pr_time = '0;
    logic [7:0]  pr_flags = '0;
    logic [15:0] pr_klen = '0;
    logic [31:0] pr_vlen = '0;

    log_record_stream_checker dut (.*);

    always #1 aclk = ~aclk;

    function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] acc;
        acc = crc ^ {24'd0, b};
        repeat (8) acc = acc[0] ? ((acc >> 1) ^ lrsc_pkg::CRC_POLY) : (acc >> 1);
        return acc;
    endfunction

    function automatic int pick_gap(input bit burst);
        if (burst || $urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(6, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic eos);
        beat_t bt;
        bt.data = b;
        bt.eos = eos;
        file_beats.insert(file_beats.size(), bt);
    endtask

    task automatic add_expected(input lrsc_pkg::result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic push_byte(input logic [7:0] b);
        add_beat(b, 1'b0);
        byte_count++;
    endtask

    task automatic push_file_header();
        logic [7:0]  hdr[32];
        logic [31:0] crc;
        crc = lrsc_pkg::CRC_INIT;
        for (int i = 0; i < 32; i++) hdr[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) hdr[i] = lrsc_pkg::MAGIC_WORD[8*i +: 8];
        hdr[4] = lrsc_pkg::FORMAT_VERSION[7:0];
        hdr[5] = lrsc_pkg::FORMAT_VERSION[15:8];
        for (int i = 0; i < 32; i++) crc = crc32c_update(crc, (i >= 24 && i < 28) ? 8'd0 : hdr[i]);
        crc = crc ^ lrsc_pkg::CRC_INIT;
        for (int i = 0; i < 4; i++) hdr[24+i] = crc[8*i +: 8];
        for (int i = 0; i < 32; i++) push_byte(hdr[i]);
    endtask

    // one entry; cut > 0 stops after that many bytes
    task automatic push_entry(input logic [63:0] seq, input logic [63:0] node,
                              input logic [63:0] tstamp, input logic [7:0] flags,
                              input logic [15:0] klen, input logic [31:0] vlen,
                              input int payload_len, input bit corrupt_crc, input int cut);
        logic [7:0]  e[$];
        logic [31:0] total;
        logic [31:0] crc;
        total = 47 + payload_len;
        crc = lrsc_pkg::CRC_INIT;
        for (int i = 0; i < 4; i++) e.insert(e.size(), total[8*i +: 8]);
        for (int i = 0; i < 8; i++) e.insert(e.size(), seq[8*i +: 8]);
        for (int i = 0; i < 8; i++) e.insert(e.size(), node[8*i +: 8]);
        for (int i = 0; i < 8; i++) e.insert(e.size(), tstamp[8*i +: 8]);
        e.insert(e.size(), flags);
        for (int i = 0; i < 8; i++) e.insert(e.size(), 8'($urandom));
        for (int i = 0; i < 2; i++) e.insert(e.size(), klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) e.insert(e.size(), vlen[8*i +: 8]);
        for (int i = 0; i < payload_len; i++) e.insert(e.size(), 8'($urandom));
        foreach (e[i]) crc = crc32c_update(crc, e[i]);
        crc = crc ^ lrsc_pkg::CRC_INIT;
        if (corrupt_crc) crc[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++) e.insert(e.size(), crc[8*i +: 8]);
        foreach (e[i]) begin
            if (cut > 0 && i >= cut) break;
            push_byte(e[i]);
        end
    endtask

    task automatic push_random_entry();
        int  klen;
        int  vlen;
        int  sel;
        sel = $urandom_range(0, 9);
        klen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
        if (sel == 0)
            push_entry({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       8'($urandom), 16'($urandom), $urandom, klen + vlen, 1'b1, 0);
        else if (sel == 1)
            push_entry({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       8'($urandom), 16'(klen + $urandom_range(0, 3)),
                       32'(vlen + $urandom_range(1, 5)), klen + vlen, 1'b0, 0);
        else
            push_entry({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       8'($urandom), 16'(klen), 32'(vlen), klen + vlen, 1'b0, 0);
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic eos);
        lrsc_pkg::result_t r;
        logic [31:0] k;
        logic [63:0] want;
        r = '0;
        k = pr_off;
        if (pr_phase == lrsc_pkg::PH_HALT) return;
        if (eos) begin
            r.kind = lrsc_pkg::KIND_STREAM;
            r.status = (pr_phase == lrsc_pkg::PH_ENTRY && k == 0) ? lrsc_pkg::ST_OK
                                                                   : lrsc_pkg::ST_TRUNCATED;
            pr_phase = lrsc_pkg::PH_HALT;
            add_expected(r);
            return;
        end
        if (pr_phase == lrsc_pkg::PH_FILE) begin
            if (k < 4) begin
                if (b != lrsc_pkg::MAGIC_WORD[8*k +: 8]) pr_hdr_bad = 1'b1;
            end else if (k < 6) begin
                if (b != lrsc_pkg::FORMAT_VERSION[8*(k-4) +: 8]) pr_hdr_bad = 1'b1;
            end
            if (k >= 24 && k < 28) begin
                pr_cap = {b, pr_cap[31:8]};
                pr_crc = crc32c_update(pr_crc, 8'd0);
            end else begin
                pr_crc = crc32c_update(pr_crc, b);
            end
            if (k < 31) begin
                pr_off = k + 1;
            end else if (pr_hdr_bad || (pr_crc ^ lrsc_pkg::CRC_INIT) != pr_cap) begin
                r.kind = lrsc_pkg::KIND_STREAM;
                r.status = lrsc_pkg::ST_BAD_HDR;
                pr_phase = lrsc_pkg::PH_HALT;
                add_expected(r);
            end else begin
                pr_phase = lrsc_pkg::PH_ENTRY;
                pr_off = 0;
                pr_crc = lrsc_pkg::CRC_INIT;
                pr_cap = 0;
            end
            return;
        end
        if (k < 4) begin
            pr_len = {b, pr_len[31:8]};
            pr_crc = crc32c_update(pr_crc, b);
            pr_off = k + 1;
            if (k == 3 && (pr_len < lrsc_pkg::MIN_ENTRY_BYTES ||
                           pr_len > lrsc_pkg::MAX_RECORD_BYTES)) begin
                r.kind = lrsc_pkg::KIND_STREAM;
                r.status = lrsc_pkg::ST_BAD_LEN;
                pr_phase = lrsc_pkg::PH_HALT;
                add_expected(r);
            end
        end else if (k < pr_len - 4) begin
            pr_crc = crc32c_update(pr_crc, b);
            pr_off = k + 1;
            if (k < 12) pr_seq = {b, pr_seq[63:8]};
            else if (k < 20) pr_node = {b, pr_node[63:8]};
            else if (k < 28) pr_time = {b, pr_time[63:8]};
            else if (k == 28) pr_flags = b;
            else if (k >= 37 && k < 39) pr_klen = {b, pr_klen[15:8]};
            else if (k >= 39 && k < 43) pr_vlen = {b, pr_vlen[31:8]};
            if (k >= lrsc_pkg::ENTRY_HDR_BYTES) begin
                r.kind = (k - lrsc_pkg::ENTRY_HDR_BYTES < pr_klen) ? lrsc_pkg::KIND_KEY
                                                                   : lrsc_pkg::KIND_VALUE;
                r.payload_byte = b;
                add_expected(r);
            end
        end else begin
            pr_cap = {b, pr_cap[31:8]};
            if (k + 1 < pr_len) begin
                pr_off = k + 1;
            end else begin
                want = 64'd47 + pr_klen + pr_vlen;
                r.kind = lrsc_pkg::KIND_VERDICT;
                if ((pr_crc ^ lrsc_pkg::CRC_INIT) != pr_cap) r.status = lrsc_pkg::ST_CRC_BAD;
                else if (want != {32'd0, pr_len}) r.status = lrsc_pkg::ST_SIZE_BAD;
                else r.status = lrsc_pkg::ST_OK;
                r.sequence_res = pr_seq;
                r.source_node = pr_node;
                r.time_stamp = pr_time;
                r.entry_flags = pr_flags;
                r.key_length = pr_klen;
                r.value_length = pr_vlen;
                add_expected(r);
                pr_off = 0;
                pr_crc = lrsc_pkg::CRC_INIT;
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if ($urandom_range(0, 63) == 0) send_burst <= ~send_burst;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (file_beats.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= file_beats[0].data;
                s_axis_tlast <= file_beats[0].eos;
                void'(file_beats.pop_front());
                send_gap <= pick_gap(send_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) recv_burst <= ~recv_burst;
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= pick_gap(recv_burst);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        lrsc_pkg::result_t seen;
        lrsc_pkg::result_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind = lrsc_pkg::kind_t'(m_axis_tuser);
                seen.payload_byte = m_axis_tdata[7:0];
                seen.status = lrsc_pkg::status_t'(m_axis_tdata[10:8]);
                seen.sequence_res = m_axis_tdata[74:11];
                seen.source_node = m_axis_tdata[138:75];
                seen.time_stamp = m_axis_tdata[202:139];
                seen.entry_flags = m_axis_tdata[210:203];
                seen.key_length = m_axis_tdata[226:211];
                seen.value_length = m_axis_tdata[258:227];
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: kind=%0d status=%0d byte=%02h",
                                 seen.kind, seen.status, seen.payload_byte);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.kind !== want.kind || seen.payload_byte !== want.payload_byte
                        || seen.status !== want.status
                        || seen.sequence_res !== want.sequence_res
                        || seen.source_node !== want.source_node
                        || seen.time_stamp !== want.time_stamp
                        || seen.entry_flags !== want.entry_flags
                        || seen.key_length !== want.key_length
                        || seen.value_length !== want.value_length) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch exp: kind=%0d byte=%02h st=%0d seq=%h node=%h",
                                     want.kind, want.payload_byte, want.status,
                                     want.sequence_res, want.source_node);
                            $display("    ts=%h flags=%02h klen=%h vlen=%h", want.time_stamp,
                                     want.entry_flags, want.key_length, want.value_length);
                            $display("  act: kind=%0d byte=%02h st=%0d seq=%h node=%h",
                                     seen.kind, seen.payload_byte, seen.status,
                                     seen.sequence_res, seen.source_node);
                            $display("    ts=%h flags=%02h klen=%h vlen=%h", seen.time_stamp,
                                     seen.entry_flags, seen.key_length, seen.value_length);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          ending;
        logic [31:0] bad_len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        push_file_header();
        // all-zero header fields, key-less entry with random payload bytes
        push_entry(64'd0, 64'd0, 64'd0, 8'h00, 16'd0, 32'd3, 3, 1'b0, 0);
        // all-ones fields: size mismatch, every payload byte is a key byte
        push_entry('1, '1, '1, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 4, 1'b0, 0);
        // crc mismatch, then a normal entry to show parsing resumes
        push_entry({$urandom, $urandom}, 64'h1, 64'h8000000000000000, 8'h5A,
                   16'd2, 32'd2, 4, 1'b1, 0);
        push_entry(64'h7, 64'h9, 64'hA, 8'h01, 16'd1, 32'd0, 1, 1'b0, 0);
        while (byte_count < TARGET_BYTES / 2) push_random_entry();

        while (file_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge aclk);

        while (byte_count < TARGET_BYTES) push_random_entry();
        ending = $urandom_range(0, 2);
        if (ending == 1) begin
            push_entry({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       8'($urandom), 16'd3, 32'd5, 8, 1'b0, $urandom_range(1, 54));
        end else if (ending == 2) begin
            bad_len = $urandom_range(0, 1) ? $urandom_range(0, 46)
                                           : lrsc_pkg::MAX_RECORD_BYTES + $urandom_range(1, 1000);
            for (int i = 0; i < 4; i++) push_byte(bad_len[8*i +: 8]);
            repeat (5) push_byte(8'($urandom));
        end
        add_beat(8'($urandom), 1'b1);

        while (file_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### log_record_stream_checker.f
hdl/lrsc_pkg.sv
hdl/lrsc_parser.sv
hdl/lrsc_fifo.sv
hdl/log_record_stream_checker.sv
hdl/lrsc_checker.sv
tb/sv/tb_top.sv
